### design/tpsc_pkg.sv
// Shared types and constants for the tachometer period/speed P controller.
// No dependencies.
package tpsc_pkg;

   localparam int PERIOD_BITS = 24;
   localparam int SPEED_BITS  = 28;
   localparam int TARGET_BITS = 28;
   localparam int DRIVE_BITS  = 16;
   localparam int COUNT_BITS  = 5;

   localparam logic [SPEED_BITS-1:0] SPEED_NUMERATOR = 28'd200000000;

   // Error width: target minus speed with a sign bit.
   localparam int ERR_BITS = TARGET_BITS + 1;
   // Errors above this saturate the drive: 10486 * 400 / 64 > 65535.
   localparam int ERR_LOW_BITS = 14;
   localparam logic [TARGET_BITS-1:0] ERR_SAT_LIMIT = 28'd10485;
   localparam int GAIN_BITS = 9;
   localparam logic [GAIN_BITS-1:0] DRIVE_GAIN = 9'd400;
   localparam int DRIVE_SHIFT = 6;
   localparam int PROD_BITS = ERR_LOW_BITS + GAIN_BITS;

   // Last divider step index (one quotient bit per step).
   localparam logic [COUNT_BITS-1:0] DIV_LAST_STEP = 5'(SPEED_BITS - 1);

   typedef struct packed {
      logic load;       // take the capture word, start the divide
      logic div_step;   // one restoring divide step
      logic err_calc;   // form the speed error
      logic mul_calc;   // scale and clamp the drive
      logic out_load;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic div_last;   // current divide step is the final one
      logic out_free;   // output register can take a word this cycle
   } status_type;

endpackage

### design/tpsc_ctrl.sv
// Sequencer for the tachometer P controller: accept, divide, error, drive, output.
// Depends on tpsc_pkg.
module tpsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tpsc_pkg::status_type status,
   output tpsc_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ERR  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_HOLD = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_calc = 1'b1;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/tpsc_dpath.sv
// Datapath: last capture, period, bit-serial speed divider, error and drive scaling,
// output register. Depends on tpsc_pkg.
module tpsc_dpath #(
   parameter int CAPTURE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tpsc_pkg::cmd_type                       cmd,
   output tpsc_pkg::status_type                    status,
   input  logic [CAPTURE_BITS-1:0]                 req_capture_value,
   input  logic                                    csr_write_enable,
   input  logic [tpsc_pkg::TARGET_BITS-1:0]        csr_write_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [tpsc_pkg::PERIOD_BITS-1:0]        rsp_period,
   output logic [tpsc_pkg::SPEED_BITS-1:0]         rsp_speed,
   output logic [tpsc_pkg::DRIVE_BITS-1:0]         rsp_drive
);

   logic [tpsc_pkg::TARGET_BITS-1:0]  target_ff;
   logic [CAPTURE_BITS-1:0]           last_capture_ff;
   logic [CAPTURE_BITS-1:0]           divisor_ff;
   logic [CAPTURE_BITS-1:0]           rem_ff;
   logic [CAPTURE_BITS-1:0]           rem_in;
   logic [tpsc_pkg::SPEED_BITS-1:0]   quo_ff;
   logic [tpsc_pkg::SPEED_BITS-1:0]   quo_in;
   logic [tpsc_pkg::COUNT_BITS-1:0]   count_ff;
   logic [tpsc_pkg::PERIOD_BITS-1:0]  period_ff;
   logic                              err_pos_ff;
   logic                              err_sat_ff;
   logic [tpsc_pkg::ERR_LOW_BITS-1:0] err_low_ff;
   logic [tpsc_pkg::DRIVE_BITS-1:0]   drive_ff;
   logic [tpsc_pkg::DRIVE_BITS-1:0]   drive_in;
   logic                              rsp_valid_ff;
   logic [tpsc_pkg::PERIOD_BITS-1:0]  rsp_period_ff;
   logic [tpsc_pkg::SPEED_BITS-1:0]   rsp_speed_ff;
   logic [tpsc_pkg::DRIVE_BITS-1:0]   rsp_drive_ff;

   logic [CAPTURE_BITS-1:0]           period_raw;
   logic [CAPTURE_BITS:0]             shifted;
   logic [CAPTURE_BITS+1:0]           diff;
   logic [tpsc_pkg::ERR_BITS-1:0]     err;
   logic [tpsc_pkg::PROD_BITS-1:0]    prod;

   // period modulo 2^CAPTURE_BITS
   assign period_raw = last_capture_ff - req_capture_value;

   // restoring divide step; remainder stays below the divisor
   assign shifted = {rem_ff, quo_ff[tpsc_pkg::SPEED_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};

   always_comb begin
      if (!diff[CAPTURE_BITS+1]) begin
         rem_in = diff[CAPTURE_BITS-1:0];
         quo_in = {quo_ff[tpsc_pkg::SPEED_BITS-2:0], 1'b1};
      end else begin
         rem_in = shifted[CAPTURE_BITS-1:0];
         quo_in = {quo_ff[tpsc_pkg::SPEED_BITS-2:0], 1'b0};
      end
   end

   // quo_ff holds the speed once the divide is done
   assign err  = {1'b0, target_ff} - {1'b0, quo_ff};
   assign prod = tpsc_pkg::PROD_BITS'(err_low_ff) * tpsc_pkg::PROD_BITS'(tpsc_pkg::DRIVE_GAIN);

   always_comb begin
      if (!err_pos_ff) begin
         drive_in = '0;
      end else if (err_sat_ff) begin
         drive_in = '1;
      end else begin
         drive_in = prod[tpsc_pkg::DRIVE_SHIFT +: tpsc_pkg::DRIVE_BITS];
      end
   end

   assign status.div_last = (count_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff       <= '0;
         last_capture_ff <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            target_ff <= csr_write_data;
         end
         if (cmd.load) begin
            last_capture_ff <= req_capture_value;
            count_ff        <= tpsc_pkg::DIV_LAST_STEP;
         end else if (cmd.div_step) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         period_ff  <= tpsc_pkg::PERIOD_BITS'(period_raw);
         divisor_ff <= (period_raw == '0) ? CAPTURE_BITS'(1) : period_raw;
         rem_ff     <= '0;
         quo_ff     <= tpsc_pkg::SPEED_NUMERATOR;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.err_calc) begin
         err_pos_ff <= !err[tpsc_pkg::ERR_BITS-1] && (err != '0);
         err_sat_ff <= err[tpsc_pkg::TARGET_BITS-1:0] > tpsc_pkg::ERR_SAT_LIMIT;
         err_low_ff <= err[tpsc_pkg::ERR_LOW_BITS-1:0];
      end
      if (cmd.mul_calc) begin
         drive_ff <= drive_in;
      end
      if (cmd.out_load) begin
         rsp_period_ff <= period_ff;
         rsp_speed_ff  <= quo_ff;
         rsp_drive_ff  <= drive_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_period = rsp_period_ff;
   assign rsp_speed  = rsp_speed_ff;
   assign rsp_drive  = rsp_drive_ff;

endmodule

### design/tach_period_speed_p_controller.sv
// Top level of the tachometer period/speed proportional controller.
// Depends on tpsc_pkg, tpsc_ctrl and tpsc_dpath.
//
// Each input word is a down-counting timer capture taken at a rising tach edge.
// The block subtracts it from the previous capture (modulo 2^CAPTURE_BITS) to get
// the period, divides 200000000 by the period (zero period counts as one) to get
// the speed, and drives a PWM duty of (target - speed) * 400 / 64 clamped to
// 0..65535. One result word per input word. The first result after reset measures
// against a previous capture of zero. Each item passes in order through an accept
// step, the bit-serial restoring divider (one quotient bit a cycle), an error step,
// a multiply step and the load of the output register, and the next word can be
// taken only after that load. The load waits, and the item takes longer, while the
// previous result still sits in the output register under rsp_stall. The divider is
// the one shared unit, so the block works on one item at a time; req_stall is high
// from acceptance until the result enters the output register, and the output
// register lets a new word be taken while the last result still waits on rsp_stall.
// The user must write the target speed through csr_write_enable/csr_write_data only
// while the block is idle; the block itself does not enforce this.
module tach_period_speed_p_controller #(
   parameter int CAPTURE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [CAPTURE_BITS-1:0]            req_capture_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tpsc_pkg::PERIOD_BITS-1:0]   rsp_period,
   output logic [tpsc_pkg::SPEED_BITS-1:0]    rsp_speed,
   output logic [tpsc_pkg::DRIVE_BITS-1:0]    rsp_drive,
   input  logic                               csr_write_enable,
   input  logic [tpsc_pkg::TARGET_BITS-1:0]   csr_write_data
);

   tpsc_pkg::cmd_type    cmd;
   tpsc_pkg::status_type status;

   // sequencer
   tpsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // period, divider, drive and output register
   tpsc_dpath #(
      .CAPTURE_BITS (CAPTURE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_capture_value (req_capture_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_period        (rsp_period),
      .rsp_speed         (rsp_speed),
      .rsp_drive         (rsp_drive)
   );

endmodule

### design/tpsc_check.sv
// Port-level checks for the tachometer P controller, bound to the top level.
// Depends on tpsc_pkg and tach_period_speed_p_controller.
module tpsc_check #(
   parameter int CAPTURE_BITS = 24
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [tpsc_pkg::PERIOD_BITS-1:0]   rsp_period,
   input logic [tpsc_pkg::SPEED_BITS-1:0]    rsp_speed,
   input logic [tpsc_pkg::DRIVE_BITS-1:0]    rsp_drive
);

   // output empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_period) && $stable(rsp_speed)
         && $stable(rsp_drive))
      else $error("stalled result changed");

   // one item at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // speed never above the numerator
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speed <= tpsc_pkg::SPEED_NUMERATOR)
      else $error("speed out of range");

   // zero period reads as full speed
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period == '0 && CAPTURE_BITS <= tpsc_pkg::PERIOD_BITS
         |-> rsp_speed == tpsc_pkg::SPEED_NUMERATOR)
      else $error("zero period speed wrong");

endmodule

bind tach_period_speed_p_controller tpsc_check #(
   .CAPTURE_BITS (CAPTURE_BITS)
) u_tpsc_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_period        (rsp_period),
   .rsp_speed         (rsp_speed),
   .rsp_drive         (rsp_drive)
);
